@@ hdl/sacl_pkg.sv @@
// shared types and constants for the lru cache tag store
// no dependencies; used by every other file of the block
package sacl_pkg;

  localparam int unsigned SETS_DEFAULT = 256;
  localparam int unsigned WAYS_DEFAULT = 8;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned LAT_W     = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LATENCY = 3'd4;

  typedef struct packed {
    logic             enable;
    logic [4:0]       line_shift;
    logic [3:0]       index_width;
    logic [3:0]       ways_in_use;
    logic [LAT_W-1:0] miss_latency;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic lookup;
    logic scan_step;
    logic commit;
    logic from_lookup;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic resolved;
    logic scan_last;
  } sts_t;

endpackage

@@ hdl/sacl_if.sv @@
// valid/ready channel interfaces for access requests and results
// depends on sacl_pkg for field widths
interface sacl_in_if;
  logic                          valid;
  logic                          ready;
  logic [sacl_pkg::ADDR_W-1:0]   address;
  logic [sacl_pkg::STAMP_W-1:0]  cycle_stamp;

  modport source (output valid, output address, output cycle_stamp, input ready);
  modport sink (input valid, input address, input cycle_stamp, output ready);
endinterface

interface sacl_out_if;
  logic                        valid;
  logic                        ready;
  logic [sacl_pkg::LAT_W-1:0]  latency;
  logic                        hit;
  logic [sacl_pkg::CNT_W-1:0]  hit_total;
  logic [sacl_pkg::CNT_W-1:0]  miss_total;

  modport source (output valid, output latency, output hit, output hit_total,
                  output miss_total, input ready);
  modport sink (input valid, input latency, input hit, input hit_total,
                input miss_total, output ready);
endinterface

@@ hdl/sacl_ctrl.sv @@
// controller state machine: clearing pass, lookup, lru scan, commit
// depends on sacl_pkg for state, command and status types
module sacl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sacl_pkg::sts_t  sts,
  output sacl_pkg::cmd_t  cmd
);

  sacl_pkg::state_t state, state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == sacl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sacl_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      sacl_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sacl_pkg::ST_LOOKUP;
        end
      end
      sacl_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (!sts.resolved) begin
          state_next = sacl_pkg::ST_SCAN;
        end else if (out_free) begin
          cmd.commit      = 1'b1;
          cmd.from_lookup = 1'b1;
          state_next      = sacl_pkg::ST_IDLE;
        end else begin
          state_next = sacl_pkg::ST_COMMIT;
        end
      end
      sacl_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = sacl_pkg::ST_COMMIT;
        end
      end
      sacl_pkg::ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sacl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/sacl_dp.sv @@
// datapath: set memory, address split, hit/victim logic, lru scan, counters
// depends on sacl_pkg; driven by commands from sacl_ctrl
module sacl_dp #(
  parameter int unsigned SETS = sacl_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS = sacl_pkg::WAYS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sacl_pkg::cfg_t                cfg,
  input  sacl_pkg::cmd_t                cmd,
  output sacl_pkg::sts_t                sts,
  input  logic [sacl_pkg::ADDR_W-1:0]   address,
  input  logic [sacl_pkg::STAMP_W-1:0]  cycle_stamp,
  output logic [sacl_pkg::LAT_W-1:0]    latency,
  output logic                          hit,
  output logic [sacl_pkg::CNT_W-1:0]    hit_total,
  output logic [sacl_pkg::CNT_W-1:0]    miss_total
);

  localparam int unsigned RW      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned MSB     = $clog2(SETS + 1) - 1;
  localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WCW     = $clog2(WAYS + 1);
  localparam logic [3:0]  MAX_SIB = 4'(MSB);

  localparam int unsigned TW = sacl_pkg::TAG_W;
  localparam int unsigned SW = sacl_pkg::STAMP_W;

  // set memory, one row per set
  logic [WAYS-1:0]         mem_valid [SETS];
  logic [WAYS-1:0][TW-1:0] mem_tag   [SETS];
  logic [WAYS-1:0][SW-1:0] mem_stamp [SETS];

  logic [WAYS-1:0]         row_valid;
  logic [WAYS-1:0][TW-1:0] row_tag;
  logic [WAYS-1:0][SW-1:0] row_stamp;

  logic [RW-1:0]  clr_cnt;
  logic [RW-1:0]  req_set;
  logic [TW-1:0]  req_tag;
  logic [SW-1:0]  req_stamp;
  logic           req_en;
  logic [WCW-1:0] ways_eff;

  logic [WW-1:0]  victim;
  logic           hit_r;
  logic [WW-1:0]  scan_idx;
  logic [SW-1:0]  best_stamp;

  logic [sacl_pkg::CNT_W-1:0] hit_cnt, miss_cnt;

  // address split
  logic [3:0]                 sib;
  logic [5:0]                 tag_shift;
  logic [sacl_pkg::ADDR_W-1:0] shifted, set_mask, set_full;
  logic [RW-1:0]              set_c;
  logic [TW-1:0]              tag_c;
  logic [4:0]                 wiu;
  logic [WCW-1:0]             ways_c;

  always_comb begin
    sib       = (cfg.index_width > MAX_SIB) ? MAX_SIB : cfg.index_width;
    shifted   = address >> cfg.line_shift;
    set_mask  = (sacl_pkg::ADDR_W'(1) << sib) - sacl_pkg::ADDR_W'(1);
    set_full  = shifted & set_mask;
    set_c     = set_full[RW-1:0];
    tag_shift = {1'b0, cfg.line_shift} + {2'b00, sib};
    tag_c     = TW'(address >> tag_shift);
    wiu       = {1'b0, cfg.ways_in_use};
    if (wiu == 5'd0) begin
      ways_c = WCW'(1);
    end else if (wiu > 5'(WAYS)) begin
      ways_c = WCW'(WAYS);
    end else begin
      ways_c = WCW'(wiu);
    end
  end

  // hit and first invalid way
  logic [WAYS-1:0] hv, iv;
  logic [WW-1:0]   hit_idx, inv_idx, victim_c;
  logic            hit_c, inv_c;

  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hv[w] = row_valid[w] && (row_tag[w] == req_tag) && (WCW'(w) < ways_eff);
      iv[w] = !row_valid[w] && (WCW'(w) < ways_eff);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hv[w]) begin
        hit_idx = WW'(w);
      end
      if (iv[w]) begin
        inv_idx = WW'(w);
      end
    end
    hit_c    = |hv;
    inv_c    = |iv;
    victim_c = hit_c ? hit_idx : (inv_c ? inv_idx : '0);
  end

  assign sts.resolved  = !req_en || hit_c || inv_c || (ways_eff == WCW'(1));
  assign sts.scan_last = ((WCW'(scan_idx) + WCW'(1)) == ways_eff);
  assign sts.clr_last  = (clr_cnt == RW'(SETS - 1));

  // commit values
  logic [WW-1:0]              cway;
  logic                       chit;
  logic [WAYS-1:0]            wr_valid;
  logic [WAYS-1:0][TW-1:0]    wr_tag;
  logic [WAYS-1:0][SW-1:0]    wr_stamp;
  logic [sacl_pkg::CNT_W-1:0] hit_cnt_next, miss_cnt_next;

  always_comb begin
    cway = cmd.from_lookup ? victim_c : victim;
    chit = cmd.from_lookup ? hit_c : hit_r;
    for (int w = 0; w < WAYS; w++) begin
      wr_valid[w] = row_valid[w] || (WW'(w) == cway);
      wr_tag[w]   = (WW'(w) == cway) ? req_tag : row_tag[w];
      wr_stamp[w] = (WW'(w) == cway) ? req_stamp : row_stamp[w];
    end
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    if (req_en) begin
      if (chit) begin
        hit_cnt_next = hit_cnt + sacl_pkg::CNT_W'(1);
      end else begin
        miss_cnt_next = miss_cnt + sacl_pkg::CNT_W'(1);
      end
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_valid <= mem_valid[set_c];
      row_tag   <= mem_tag[set_c];
      row_stamp <= mem_stamp[set_c];
    end
    if (cmd.clr_step) begin
      mem_valid[clr_cnt] <= '0;
    end else if (cmd.commit && req_en) begin
      mem_valid[req_set] <= wr_valid;
      mem_tag[req_set]   <= wr_tag;
      mem_stamp[req_set] <= wr_stamp;
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_set   <= set_c;
      req_tag   <= tag_c;
      req_stamp <= cycle_stamp;
      req_en    <= cfg.enable;
      ways_eff  <= ways_c;
    end
    if (cmd.lookup) begin
      victim     <= victim_c;
      hit_r      <= hit_c;
      best_stamp <= row_stamp[0];
      scan_idx   <= WW'(1);
    end
    if (cmd.scan_step) begin
      if (row_stamp[scan_idx] < best_stamp) begin
        victim     <= scan_idx;
        best_stamp <= row_stamp[scan_idx];
      end
      scan_idx <= scan_idx + WW'(1);
    end
    if (cmd.commit) begin
      latency    <= (req_en && !chit) ? cfg.miss_latency : '0;
      hit        <= req_en && chit;
      hit_total  <= hit_cnt_next;
      miss_total <= miss_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + RW'(1);
      end
      if (cmd.commit) begin
        hit_cnt  <= hit_cnt_next;
        miss_cnt <= miss_cnt_next;
      end
    end
  end

endmodule

@@ hdl/set_assoc_cache_lru_tags_top.sv @@
// Tag store of a set-associative cache with timestamp LRU replacement. After reset the
// block runs a clearing pass, one set per cycle, during which no access is taken. An
// access that hits, finds an invalid way, uses one way or finds the cache disabled
// goes from set read to row write-back (no write when disabled); a miss in a full set
// first scans the ways in use (ways_in_use clamped to 1..WAYS) for the oldest stamp
// with a compare unit that looks at one way per cycle. One access is in flight at a
// time; a finished result waits in an output register while the next access is taken.
// The user must write configuration registers through cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this.
// depends on sacl_pkg, sacl_if, sacl_ctrl and sacl_dp
module set_assoc_cache_lru_tags_top #(
  parameter int unsigned SETS = sacl_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS = sacl_pkg::WAYS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::CFG_DAT_W-1:0]      cfg_data,
  sacl_in_if.sink                             access,
  sacl_out_if.source                          result
);

  sacl_pkg::cfg_t cfg;
  sacl_pkg::cmd_t cmd;
  sacl_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b1;
      cfg.line_shift   <= 5'd6;
      cfg.index_width  <= 4'd8;
      cfg.ways_in_use  <= 4'd8;
      cfg.miss_latency <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacl_pkg::CFG_ENABLE:       cfg.enable       <= cfg_data[0];
        sacl_pkg::CFG_LINE_SHIFT:   cfg.line_shift   <= cfg_data[4:0];
        sacl_pkg::CFG_INDEX_WIDTH:  cfg.index_width  <= cfg_data[3:0];
        sacl_pkg::CFG_WAYS_IN_USE:  cfg.ways_in_use  <= cfg_data[3:0];
        sacl_pkg::CFG_MISS_LATENCY: cfg.miss_latency <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (access.valid),
    .in_ready  (access.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sacl_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .address     (access.address),
    .cycle_stamp (access.cycle_stamp),
    .latency     (result.latency),
    .hit         (result.hit),
    .hit_total   (result.hit_total),
    .miss_total  (result.miss_total)
  );

endmodule
